// ----- rtl/ptd_pkg.sv -----
// Package with widths, constants and state types for the trial-division prime tester.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  localparam logic [WIDTH-1:0] TWO       = WIDTH'(2);
  localparam logic [WIDTH-1:0] THREE     = WIDTH'(3);
  localparam logic [WIDTH-1:0] FIRST_DIV = WIDTH'(5);
  localparam logic [WIDTH-1:0] PAIR_GAP  = WIDTH'(2);
  localparam logic [WIDTH-1:0] STEP      = WIDTH'(6);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(WIDTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRY,
    S_DIV,
    S_DONE
  } state_t;

  // Which divisor the running division belongs to.
  typedef enum logic [1:0] {
    PH_THREE,
    PH_LO,
    PH_HI
  } phase_t;

endpackage

// ----- rtl/prime_test_trial_division_unit.sv -----
// Top level of the trial-division prime tester with its shared serial divider.
`timescale 1ns / 1ps

// Tests one signed number per transaction and returns is_prime. Values below 4 and
// even values skip the divider and go straight to the done state. Every other value
// goes through one shared restoring divider, one remainder at a time: first the
// divisor 3, then the pairs d and d+2 (d = 5, 11, 17, ...) while d*d does not exceed the
// number, each pair preceded by a compare step. For 16-bit values at most 30 pairs
// are tried, and most composites stop far earlier, at the first zero remainder. The
// block accepts no new number until the current result has moved into the output
// register; that register holds the result until it is taken, while the next number
// may already be accepted.
module prime_test_trial_division_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             number_valid,
  output logic                             number_ready,
  input  logic signed [ptd_pkg::WIDTH-1:0] number,
  output logic                             is_prime_valid,
  input  logic                             is_prime_ready,
  output logic                             is_prime
);

  localparam int W = ptd_pkg::WIDTH;

  ptd_pkg::state_t state, state_next;
  ptd_pkg::phase_t phase, phase_next;

  logic [W-1:0]             n, n_next;
  logic [W-1:0]             d, d_next;
  logic [W-1:0]             divisor, divisor_next;
  logic [W-1:0]             rem, rem_next;
  logic [W-1:0]             dsh, dsh_next;
  logic [ptd_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                     result, result_next;

  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  logic [W-1:0] rem_step;
  logic [2*W-1:0] d_sq;
  logic         slot_free;
  logic         load_out;

  assign number_ready = (state == ptd_pkg::S_IDLE);
  assign slot_free    = !is_prime_valid || is_prime_ready;

  // One restoring step of the shared divider.
  assign rem_sh   = {rem, dsh[W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign rem_step = (rem_sh >= {1'b0, divisor}) ? rem_sub[W-1:0] : rem_sh[W-1:0];

  assign d_sq = {{W{1'b0}}, d} * {{W{1'b0}}, d};

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    n_next       = n;
    d_next       = d;
    divisor_next = divisor;
    rem_next     = rem;
    dsh_next     = dsh;
    cnt_next     = cnt;
    result_next  = result;
    load_out     = 1'b0;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        if (number_valid) begin
          n_next       = number;
          rem_next     = '0;
          dsh_next     = number;
          cnt_next     = '0;
          divisor_next = ptd_pkg::THREE;
          phase_next   = ptd_pkg::PH_THREE;
          d_next       = ptd_pkg::FIRST_DIV;
          if (number[W-1] || (number < ptd_pkg::TWO)) begin
            result_next = 1'b0;
            state_next  = ptd_pkg::S_DONE;
          end else if (number <= ptd_pkg::THREE) begin
            result_next = 1'b1;
            state_next  = ptd_pkg::S_DONE;
          end else if (!number[0]) begin
            result_next = 1'b0;
            state_next  = ptd_pkg::S_DONE;
          end else begin
            state_next = ptd_pkg::S_DIV;
          end
        end
      end
      ptd_pkg::S_TRY: begin
        rem_next = '0;
        dsh_next = n;
        cnt_next = '0;
        if (d_sq > {{W{1'b0}}, n}) begin
          result_next = 1'b1;
          state_next  = ptd_pkg::S_DONE;
        end else begin
          divisor_next = d;
          phase_next   = ptd_pkg::PH_LO;
          state_next   = ptd_pkg::S_DIV;
        end
      end
      ptd_pkg::S_DIV: begin
        rem_next = rem_step;
        dsh_next = {dsh[W-2:0], 1'b0};
        cnt_next = cnt + 1'b1;
        if (cnt == ptd_pkg::LAST_BIT) begin
          cnt_next = '0;
          if (rem_step == '0) begin
            result_next = 1'b0;
            state_next  = ptd_pkg::S_DONE;
          end else begin
            case (phase)
              ptd_pkg::PH_LO: begin
                // Second divisor of the pair; restart the divider on the same number.
                rem_next     = '0;
                dsh_next     = n;
                divisor_next = d + ptd_pkg::PAIR_GAP;
                phase_next   = ptd_pkg::PH_HI;
              end
              ptd_pkg::PH_HI: begin
                d_next     = d + ptd_pkg::STEP;
                state_next = ptd_pkg::S_TRY;
              end
              default: begin
                state_next = ptd_pkg::S_TRY;
              end
            endcase
          end
        end
      end
      ptd_pkg::S_DONE: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ptd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ptd_pkg::S_IDLE;
      phase          <= ptd_pkg::PH_THREE;
      cnt            <= '0;
      is_prime_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      if (load_out) begin
        is_prime_valid <= 1'b1;
      end else if (is_prime_ready) begin
        is_prime_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    d       <= d_next;
    divisor <= divisor_next;
    rem     <= rem_next;
    dsh     <= dsh_next;
    result  <= result_next;
    if (load_out) begin
      is_prime <= result;
    end
  end

endmodule

// ----- rtl/ptd_checker.sv -----
// Port-level checker for the prime tester and its bind to the top level.
`timescale 1ns / 1ps

module ptd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             number_valid,
  input logic                             number_ready,
  input logic signed [ptd_pkg::WIDTH-1:0] number,
  input logic                             is_prime_valid,
  input logic                             is_prime_ready,
  input logic                             is_prime
);

  // A held result stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    is_prime_valid && !is_prime_ready |=> is_prime_valid && $stable(is_prime))
    else $error("result changed or dropped while stalled");

  // A waiting number stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    number_valid && !number_ready |=> number_valid && $stable(number))
    else $error("number changed or dropped while waiting");

  // After a number is accepted the block is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    number_valid && number_ready |=> !number_ready)
    else $error("ready stayed high after an accepted transaction");

  // A fresh result is written exactly when the block returns to idle.
  a_result_frees_block: assert property (@(posedge clk) disable iff (rst)
    $rose(is_prime_valid) |-> number_ready)
    else $error("result appeared while the block was still busy");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !is_prime_valid)
    else $error("result valid right after reset");

endmodule

bind prime_test_trial_division_unit ptd_checker u_ptd_checker (
  .clk            (clk),
  .rst            (rst),
  .number_valid   (number_valid),
  .number_ready   (number_ready),
  .number         (number),
  .is_prime_valid (is_prime_valid),
  .is_prime_ready (is_prime_ready),
  .is_prime       (is_prime)
);
